// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the tokenizer core.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define SVT_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tokenizer assertion failed");
// consequent holds in the same cycle as the antecedent
`define SVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");
`else
`define SVT_ASSERT(lbl, cond)
`define SVT_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/svt_pkg.sv =====
// Shared types, character codes and event kinds for the tokenizer core.
// No dependencies.
package svt_pkg;

	localparam int CHAR_WIDTH = 16;
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [15:0] CHAR_MASK = 16'((32'd1 << CHAR_WIDTH) - 32'd1);

	localparam logic [15:0] CH_NUL    = 16'h0000;
	localparam logic [15:0] CH_HASH   = 16'h0023;
	localparam logic [15:0] CH_NL     = 16'h000A;
	localparam logic [15:0] CH_EQ     = 16'h003D;
	localparam logic [15:0] CH_SQUOTE = 16'h0027;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_BTICK  = 16'h0060;
	localparam logic [15:0] CH_DOLLAR = 16'h0024;

	// event kinds on the result channel
	typedef enum logic [3:0] {
		K_NAME_CHAR  = 4'd0,
		K_NAME_EQ    = 4'd1,
		K_NAME_END   = 4'd2,
		K_VAL_START  = 4'd3,
		K_VAL_CHAR   = 4'd4,
		K_COMMIT     = 4'd5,
		K_MISSING    = 4'd6,
		K_CANCELLED  = 4'd7,
		K_OK         = 4'd8,
		K_INVALID    = 4'd9,
		K_EMPTY      = 4'd10
	} kind_t;

	typedef logic [1:0] evcnt_t;

	// events raised by one character, slot 0 first
	typedef struct packed {
		evcnt_t                      n;
		kind_t [MAX_RES-1:0]         kind;
		logic [MAX_RES-1:0][15:0]    chr;
	} evq_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic is_space(logic [15:0] c);
		return c == 16'h0020 || c == 16'h0009 || c == 16'h000D ||
			c == 16'h000A || c == 16'h000B || c == 16'h000C;
	endfunction

	// append one event to the list, dropping any beyond the slot count
	function automatic evq_t ev_put(evq_t q, kind_t k, logic [15:0] c);
		evq_t r;
		r = q;
		if (r.n < evcnt_t'(MAX_RES)) begin
			r.kind[r.n] = k;
			r.chr[r.n]  = c;
			r.n         = r.n + 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/svt_front.sv =====
// Front end: accepts characters, runs the tokenizer state and builds event lists.
// Depends on svt_pkg.
module svt_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic         cfg_wdata,
	input  logic         in_valid,
	input  logic [15:0]  ch,
	input  logic         fifo_full,
	output logic         push,
	output svt_pkg::evq_t entry
);
	import svt_pkg::*;

	typedef enum logic [2:0] {
		M_WS, M_COMMENT, M_NAME, M_VALUE, M_QUOTED, M_SHELL
	} mode_t;
	typedef enum logic [1:0] {Q_NONE, Q_SINGLE, Q_DOUBLE} quote_t;
	typedef enum logic [1:0] {E_NONE, E_PLAIN, E_DQ} esc_t;

	mode_t  mode_q, saved_q;
	quote_t quote_q;
	esc_t   esc_q;
	logic   vne_q, seen_q, tok_only_q;

	mode_t  m, sm;
	quote_t qk;
	esc_t   ep;
	logic   vn, is;
	evq_t   ev;
	logic   done, do_hv, do_vend, do_fin, accept;
	logic [15:0] c, qc;

	assign c      = ch & CHAR_MASK;
	assign accept = in_valid && !fifo_full;
	assign push   = accept && (ev.n != 2'd0);
	assign entry  = ev;

	// next state and events for this character
	always_comb begin
		m = mode_q; sm = saved_q; qk = quote_q; ep = esc_q;
		vn = vne_q; is = seen_q;
		ev = '0;
		done = 1'b0; do_hv = 1'b0; do_vend = 1'b0; do_fin = 1'b0;
		qc = CH_SQUOTE;

		// character after a backslash
		if (ep == E_PLAIN) begin
			ep   = E_NONE;
			done = 1'b1;
			if (c == CH_NUL) begin
				m      = M_VALUE;
				ep     = E_PLAIN;
				do_fin = 1'b1;
			end else begin
				ev = ev_put(ev, K_VAL_CHAR, c);
				vn = 1'b1;
			end
		end else if (ep == E_DQ) begin
			ep = E_NONE;
			if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BTICK) begin
				ev   = ev_put(ev, K_VAL_CHAR, c);
				done = 1'b1;
			end else begin
				ev = ev_put(ev, K_VAL_CHAR, CH_BSLASH);
			end
		end

		// per-mode handling
		if (!done) begin
			unique case (m)
				M_COMMENT: begin
					if (c == CH_NL) m = M_WS;
					else if (c == CH_NUL) do_fin = 1'b1;
				end
				M_NAME: begin
					if (c == CH_EQ) begin
						ev = ev_put(ev, K_NAME_EQ, 16'd0);
						is = 1'b1;
						m  = M_VALUE;
						vn = 1'b0;
						sm = M_WS;
					end else if (c == CH_NUL || is_space(c)) begin
						ev = ev_put(ev, K_NAME_END, 16'd0);
						is = 1'b1;
						m  = M_WS;
						if (c == CH_NUL) do_fin = 1'b1;
					end else begin
						ev = ev_put(ev, K_NAME_CHAR, c);
					end
				end
				M_SHELL: begin
					if (c == CH_BTICK) m = sm;
					else if (c == CH_NUL) do_fin = 1'b1;
				end
				M_VALUE, M_QUOTED: do_hv = 1'b1;
				default: begin
					if (c == CH_HASH) begin
						m = M_COMMENT;
					end else if (c == CH_NUL) begin
						do_fin = 1'b1;
					end else if (!is_space(c)) begin
						if (tok_only_q) begin
							ev    = ev_put(ev, K_VAL_START, 16'd0);
							is    = 1'b1;
							m     = M_VALUE;
							vn    = 1'b0;
							sm    = M_WS;
							do_hv = 1'b1;
						end else begin
							m  = M_NAME;
							ev = ev_put(ev, K_NAME_CHAR, c);
						end
					end
				end
			endcase
		end

		// value text, bare or quoted
		if (do_hv) begin
			if (m == M_VALUE) begin
				if (c == CH_SQUOTE || c == CH_DQUOTE) begin
					qk = (c == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
					m  = M_QUOTED;
					vn = 1'b1;
				end else if (c == CH_BSLASH) begin
					ep = E_PLAIN;
					vn = 1'b1;
				end else if (c == CH_BTICK) begin
					sm = M_VALUE;
					m  = M_SHELL;
					vn = 1'b1;
				end else if (c == CH_NUL || is_space(c)) begin
					do_vend = 1'b1;
					if (c == CH_NUL) do_fin = 1'b1;
				end else begin
					ev = ev_put(ev, K_VAL_CHAR, c);
					vn = 1'b1;
				end
			end else begin
				qc = (qk == Q_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
				if (c == qc) begin
					m  = M_VALUE;
					qk = Q_NONE;
				end else if (c == CH_BSLASH && qk == Q_DOUBLE) begin
					ep = E_DQ;
				end else if (c == CH_BTICK) begin
					sm = M_QUOTED;
					m  = M_SHELL;
				end else if (c == CH_NUL) begin
					do_fin = 1'b1;
				end else begin
					ev = ev_put(ev, K_VAL_CHAR, c);
				end
			end
		end

		// end of value
		if (do_vend) begin
			if (!vn) ev = ev_put(ev, K_MISSING, 16'd0);
			else if (sm != M_WS) ev = ev_put(ev, K_CANCELLED, 16'd0);
			else ev = ev_put(ev, K_COMMIT, 16'd0);
			sm = M_WS;
			vn = 1'b0;
			m  = M_WS;
		end

		// end of string: status then clear string state
		if (do_fin) begin
			if (m != M_WS || sm != M_WS || ep != E_NONE) ev = ev_put(ev, K_INVALID, 16'd0);
			else if (is) ev = ev_put(ev, K_OK, 16'd0);
			else ev = ev_put(ev, K_EMPTY, 16'd0);
			m = M_WS; sm = M_WS; qk = Q_NONE; ep = E_NONE;
			vn = 1'b0; is = 1'b0;
		end
	end

	// tokenizer state and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_WS;
			saved_q    <= M_WS;
			quote_q    <= Q_NONE;
			esc_q      <= E_NONE;
			vne_q      <= 1'b0;
			seen_q     <= 1'b0;
			tok_only_q <= 1'b0;
		end else begin
			if (cfg_wen) tok_only_q <= cfg_wdata;
			if (accept) begin
				mode_q  <= m;
				saved_q <= sm;
				quote_q <= qk;
				esc_q   <= ep;
				vne_q   <= vn;
				seen_q  <= is;
			end
		end
	end

endmodule

// ===== rtl/core/svt_fifo.sv =====
// Short queue of event lists between front and back end.
// Depends on svt_pkg.
module svt_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  svt_pkg::evq_t      wr_entry,
	input  logic               pop,
	output svt_pkg::evq_t      head,
	output svt_pkg::fifo_stat_t stat
);
	import svt_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	evq_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign stat.full  = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wr_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/svt_back.sv =====
// Back end: unpacks queued event lists, one result beat per cycle while not stalled.
// Depends on svt_pkg.
module svt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  svt_pkg::evq_t       head,
	input  svt_pkg::fifo_stat_t stat,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [3:0]          kind,
	output logic [15:0]         chr,
	output logic                last
);
	import svt_pkg::*;

	evcnt_t idx_q;
	logic   valid_q, last_q;
	kind_t  kind_q;
	logic [15:0] chr_q;
	logic   load, is_last;

	assign load    = !stat.empty && (!valid_q || !out_stall);
	assign is_last = (idx_q == head.n - 2'd1);
	assign pop     = load && is_last;

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign chr       = chr_q;
	assign last      = last_q;

	// output register and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.kind[idx_q];
			chr_q  <= head.chr[idx_q];
			last_q <= is_last;
		end
	end

endmodule

// ===== rtl/core/shell_var_tokenizer_core.sv =====
// Shell-style name=value tokenizer: one character in, a stream of event beats out.
// A character's events are written into the queue, then loaded into the output register.
// Throughput: one character per cycle while the queue is not full; the result port moves
// one beat per cycle while out_stall is low, one beat per result (4-entry queue).
// Reset (arst_n, asynchronous): whitespace mode, queue empty, tokens_only cleared.
module shell_var_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [15:0] chr,
	output logic        last
);
	import svt_pkg::*;

	`include "assert_macros.svh"

	evq_t       entry, head;
	fifo_stat_t fstat;
	logic       push, pop;

	assign in_stall = fstat.full;

	svt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.ch        (ch),
		.fifo_full (fstat.full),
		.push      (push),
		.entry     (entry)
	);

	svt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.stat     (fstat)
	);

	svt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (fstat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.chr       (chr),
		.last      (last)
	);

	// queued lists always hold at least one event
	`SVT_ASSERT_IMP(a_head_nonempty, !fstat.empty, head.n != 2'd0)
	// a final status beat closes its character's results
	`SVT_ASSERT_IMP(a_status_last, out_valid && kind >= K_OK, last)
	// no kind code beyond the defined set reaches the port
	`SVT_ASSERT_IMP(a_kind_range, out_valid, kind <= K_EMPTY)

endmodule

// ===== dv/shell_var_tokenizer_core_tb.sv =====
// Self-checking testbench for shell_var_tokenizer_core: drives characters and
// checks every event beat against a behavioural tokenizer kept in this file.
// Depends on svt_pkg (event kinds, character codes) and the core RTL only.
module shell_var_tokenizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import svt_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_CHARS   = 30;

	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_VT    = 16'h000B;
	localparam logic [15:0] CH_FF    = 16'h000C;
	localparam logic [15:0] CH_TOP   = 16'hFFFF;

	typedef enum logic [2:0] {TS_WS, TS_COMMENT, TS_NAME, TS_VALUE, TS_QUOTED, TS_SHELL} tok_mode_t;
	typedef enum logic [1:0] {QK_NONE, QK_SINGLE, QK_DOUBLE} quote_t;
	typedef enum logic [1:0] {ESC_NONE, ESC_BARE, ESC_DQ} esc_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] chr;
		logic        last;
	} tok_ev_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] ch = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  kind;
	logic [15:0] chr;
	logic        last;

	// tokenizer state as predicted
	tok_mode_t   p_mode = TS_WS;
	tok_mode_t   p_saved = TS_WS;
	quote_t      p_quote = QK_NONE;
	esc_t        p_esc = ESC_NONE;
	bit          p_nonempty = 1'b0;
	bit          p_seen = 1'b0;
	bit          p_tokens_only = 1'b0;

	tok_ev_t     step_evs[$];
	tok_ev_t     pending_events[$];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned chars_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	shell_var_tokenizer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.chr       (chr),
		.last      (last)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// ------------------------------------------------------------------
	// Behavioural tokenizer
	// ------------------------------------------------------------------

	function automatic bit is_blank(logic [15:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL ||
			c == CH_VT || c == CH_FF;
	endfunction

	// queue one event for the current character; at most MAX_RES per character
	function automatic void note(kind_t k, logic [15:0] c);
		tok_ev_t ev;
		ev.kind = k;
		ev.chr  = c;
		ev.last = 1'b0;
		if (step_evs.size() < MAX_RES)
			step_evs.push_back(ev);
	endfunction

	function automatic void restart_string();
		p_mode     = TS_WS;
		p_saved    = TS_WS;
		p_quote    = QK_NONE;
		p_esc      = ESC_NONE;
		p_nonempty = 1'b0;
		p_seen     = 1'b0;
	endfunction

	// status at NUL, then back to a fresh string
	function automatic void end_of_string();
		if (p_mode != TS_WS || p_saved != TS_WS || p_esc != ESC_NONE)
			note(K_INVALID, '0);
		else if (p_seen)
			note(K_OK, '0);
		else
			note(K_EMPTY, '0);
		restart_string();
	endfunction

	function automatic void close_value();
		if (!p_nonempty)
			note(K_MISSING, '0);
		else if (p_saved != TS_WS)
			note(K_CANCELLED, '0);
		else
			note(K_COMMIT, '0);
		p_saved    = TS_WS;
		p_nonempty = 1'b0;
		p_mode     = TS_WS;
	endfunction

	// one character inside a value, bare or quoted
	function automatic void value_char(logic [15:0] c);
		logic [15:0] closer;
		if (p_mode == TS_VALUE) begin
			if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				p_quote    = (c == CH_DQUOTE) ? QK_DOUBLE : QK_SINGLE;
				p_mode     = TS_QUOTED;
				p_nonempty = 1'b1;
			end else if (c == CH_BSLASH) begin
				p_esc      = ESC_BARE;
				p_nonempty = 1'b1;
			end else if (c == CH_BTICK) begin
				p_saved    = TS_VALUE;
				p_mode     = TS_SHELL;
				p_nonempty = 1'b1;
			end else if (c == CH_NUL || is_blank(c)) begin
				close_value();
				if (c == CH_NUL)
					end_of_string();
			end else begin
				note(K_VAL_CHAR, c);
				p_nonempty = 1'b1;
			end
		end else begin
			closer = (p_quote == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
			if (c == closer) begin
				p_mode  = TS_VALUE;
				p_quote = QK_NONE;
			end else if (c == CH_BSLASH && p_quote == QK_DOUBLE) begin
				p_esc = ESC_DQ;
			end else if (c == CH_BTICK) begin
				p_saved = TS_QUOTED;
				p_mode  = TS_SHELL;
			end else if (c == CH_NUL) begin
				end_of_string();
			end else begin
				note(K_VAL_CHAR, c);
			end
		end
	endfunction

	// work out the beats one accepted character raises and queue them
	function automatic void tokenize_char(logic [15:0] c);
		bit handled;
		handled = 1'b0;
		step_evs.delete();
		// escape carried over from the previous character
		if (p_esc == ESC_BARE) begin
			p_esc = ESC_NONE;
			if (c == CH_NUL) begin
				p_mode = TS_VALUE;
				p_esc  = ESC_BARE;
				end_of_string();
			end else begin
				note(K_VAL_CHAR, c);
				p_nonempty = 1'b1;
			end
			handled = 1'b1;
		end else if (p_esc == ESC_DQ) begin
			p_esc = ESC_NONE;
			if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BTICK) begin
				note(K_VAL_CHAR, c);
				handled = 1'b1;
			end else begin
				note(K_VAL_CHAR, CH_BSLASH);
			end
		end
		if (!handled) begin
			case (p_mode)
			TS_COMMENT: begin
				if (c == CH_NL)
					p_mode = TS_WS;
				else if (c == CH_NUL)
					end_of_string();
			end
			TS_NAME: begin
				if (c == CH_EQ) begin
					note(K_NAME_EQ, '0);
					p_seen     = 1'b1;
					p_mode     = TS_VALUE;
					p_nonempty = 1'b0;
					p_saved    = TS_WS;
				end else if (c == CH_NUL || is_blank(c)) begin
					note(K_NAME_END, '0);
					p_seen = 1'b1;
					p_mode = TS_WS;
					if (c == CH_NUL)
						end_of_string();
				end else begin
					note(K_NAME_CHAR, c);
				end
			end
			TS_SHELL: begin
				if (c == CH_BTICK)
					p_mode = p_saved;
				else if (c == CH_NUL)
					end_of_string();
			end
			TS_VALUE, TS_QUOTED: value_char(c);
			default: begin
				if (c == CH_HASH) begin
					p_mode = TS_COMMENT;
				end else if (c == CH_NUL) begin
					end_of_string();
				end else if (!is_blank(c)) begin
					if (p_tokens_only) begin
						note(K_VAL_START, '0);
						p_seen     = 1'b1;
						p_mode     = TS_VALUE;
						p_nonempty = 1'b0;
						p_saved    = TS_WS;
						value_char(c);
					end else begin
						p_mode = TS_NAME;
						note(K_NAME_CHAR, c);
					end
				end
			end
			endcase
		end
		if (step_evs.size() != 0)
			step_evs[step_evs.size() - 1].last = 1'b1;
		foreach (step_evs[i])
			pending_events.push_back(step_evs[i]);
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : result_check
		tok_ev_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("beat with nothing expected: kind=%0d chr=%h last=%b",
					kind, chr, last));
			end else begin
				want = pending_events.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d (%s)",
						kind, want.kind, want.kind.name()));
				if (chr !== want.chr)
					report_mismatch($sformatf("chr %h, expected %h (kind %s)",
						chr, want.chr, want.kind.name()));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, expected %b (kind %s)",
						last, want.last, want.kind.name()));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic bit roll(int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	// idle mix: none, sender gaps, receiver stalls, both
	task automatic set_idle(input int unsigned phase);
		case (phase % 4)
		0: begin send_idle_pct = 0;  stall_pct = 0;  end
		1: begin send_idle_pct = 59; stall_pct = 0;  end
		2: begin send_idle_pct = 0;  stall_pct = 59; end
		default: begin send_idle_pct = 25; stall_pct = 25; end
		endcase
	endtask

	// one input beat; returns at the edge that takes it
	task automatic send_char(input logic [15:0] c);
		while (roll(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		do @(posedge clk); while (in_stall);
		tokenize_char(c);
		chars_sent++;
	endtask

	// stop sending and let every expected beat out, plus a margin for silent chars
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tokens_only(input bit v);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		p_tokens_only = v;
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [15:0] pick_letter();
		return 16'h0061 + 16'($urandom_range(25));
	endfunction

	function automatic logic [15:0] pick_blank();
		case ($urandom_range(5))
		0: return CH_SPACE;
		1: return CH_TAB;
		2: return CH_CR;
		3: return CH_NL;
		4: return CH_VT;
		default: return CH_FF;
		endcase
	endfunction

	// plain value text: mostly letters, sometimes wide characters
	function automatic logic [15:0] pick_text();
		if ($urandom_range(99) < 85)
			return pick_letter();
		return 16'($urandom_range(16'h0080, 16'hFFFF));
	endfunction

	// anything at all, weighted towards the characters the tokenizer cares about
	function automatic logic [15:0] pick_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35) return pick_letter();
		if (r < 47) return pick_blank();
		if (r < 52) return CH_HASH;
		if (r < 58) return CH_EQ;
		if (r < 64) return CH_SQUOTE;
		if (r < 70) return CH_DQUOTE;
		if (r < 77) return CH_BSLASH;
		if (r < 83) return CH_BTICK;
		if (r < 86) return CH_DOLLAR;
		if (r < 90) return CH_NUL;
		return 16'($urandom);
	endfunction

	task automatic send_expansion();
		send_char(CH_BTICK);
		repeat ($urandom_range(0, 3)) send_char(pick_char() == CH_NUL ? CH_DOLLAR : pick_text());
		send_char(CH_BTICK);
	endtask

	// one piece of double-quoted text
	task automatic send_dq_piece();
		case ($urandom_range(5))
		0, 1: send_char(pick_text());
		2: begin
			send_char(CH_BSLASH);
			case ($urandom_range(3))
			0: send_char(CH_DQUOTE);
			1: send_char(CH_BSLASH);
			2: send_char(CH_DOLLAR);
			default: send_char(CH_BTICK);
			endcase
		end
		3: begin
			send_char(CH_BSLASH);
			send_char(pick_text());
		end
		4: send_char(CH_DOLLAR);
		default: send_expansion();
		endcase
	endtask

	// a value made of bare, quoted, escaped and expanded parts
	task automatic send_value();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(4))
			0: repeat ($urandom_range(1, 3)) send_char(pick_text());
			1: begin
				send_char(CH_BSLASH);
				send_char(pick_char());
			end
			2: begin
				send_char(CH_SQUOTE);
				repeat ($urandom_range(0, 3)) send_char(pick_text());
				if ($urandom_range(4) == 0)
					send_expansion();
				send_char(CH_SQUOTE);
			end
			3: begin
				send_char(CH_DQUOTE);
				repeat ($urandom_range(0, 3)) send_dq_piece();
				send_char(CH_DQUOTE);
			end
			default: send_expansion();
			endcase
		end
	endtask

	// one string of assignments or tokens ended by NUL, now and then left open
	task automatic send_script();
		int unsigned n_items;
		int unsigned j;
		n_items = $urandom_range(1, 3);
		for (j = 0; j < n_items; j++) begin
			if ($urandom_range(9) == 0) begin
				send_char(CH_HASH);
				repeat ($urandom_range(0, 3)) send_char(pick_text());
				send_char(CH_NL);
			end
			if (p_tokens_only) begin
				send_value();
			end else begin
				repeat ($urandom_range(1, 3)) send_char(pick_letter());
				if ($urandom_range(4) != 0) begin
					send_char(CH_EQ);
					send_value();
				end
			end
			if (j + 1 < n_items || $urandom_range(1) == 0)
				send_char(pick_blank());
		end
		case ($urandom_range(9))
		0: send_char(CH_DQUOTE);
		1: send_char(CH_BSLASH);
		2: send_char(CH_BTICK);
		3: send_char(CH_HASH);
		default: ;
		endcase
		send_char(CH_NUL);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// comment, name=value with double-quote escapes, missing value, bare name,
	// empty quotes, status ok and empty
	task automatic test_directed_names();
		logic [15:0] beats[$];
		set_idle(0);
		write_tokens_only(1'b0);
		beats = '{CH_HASH, 16'h0063, CH_NL,
			16'h006E, CH_EQ, CH_DQUOTE, CH_BSLASH, 16'h0071, CH_BSLASH, CH_DQUOTE,
			CH_DQUOTE, CH_SPACE,
			16'h006B, CH_EQ, CH_SPACE,
			16'h006D, CH_SPACE,
			16'h0065, CH_EQ, CH_DQUOTE, CH_DQUOTE, CH_NUL,
			CH_NUL};
		foreach (beats[i])
			send_char(beats[i]);
		drain();
	endtask

	// bare tokens: cancelled expansion, escaped top character, expansion inside
	// single quotes, string ending after a backslash
	task automatic test_directed_tokens();
		logic [15:0] beats[$];
		set_idle(3);
		write_tokens_only(1'b1);
		beats = '{CH_BTICK, 16'h0078, CH_BTICK, CH_SPACE,
			CH_BSLASH, CH_TOP, CH_SQUOTE, CH_BTICK, CH_BTICK, CH_SQUOTE, CH_NUL,
			CH_BSLASH, CH_NUL};
		foreach (beats[i])
			send_char(beats[i]);
		drain();
	endtask

	// mostly well-formed strings, some noise, through every idle mix and both settings
	task automatic test_random_streams(input bit first_setting);
		int unsigned phase;
		int unsigned start;
		for (phase = 0; phase < 4; phase++) begin
			set_idle(phase);
			write_tokens_only(first_setting ^ phase[0]);
			start = chars_sent;
			while (chars_sent - start < PHASE_CHARS) begin
				if (roll(85))
					send_script();
				else
					repeat ($urandom_range(1, 8)) send_char(pick_char());
			end
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_names();
		test_directed_tokens();
		test_random_streams(1'b0);
		test_random_streams(1'b1);

		drain();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
